FILE: hw/rtl/izhnp_pkg.sv
package izhnp_pkg;

	// Pool size and the width of a neuron address within the state arrays.
	localparam int NEURONS = 10;
	localparam int IDX_W   = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	// Fixed widths of the stream and register fields.
	localparam int NIDX_W = 5;
	localparam int CNT_W  = 6;
	localparam int SUM_W  = 40;

	// Q16.16 constants of the neuron equations.
	localparam logic signed [31:0] K_0P04    = 32'sd2621;
	localparam logic signed [31:0] K_0P02    = 32'sd1311;
	localparam logic signed [31:0] K_0P2     = 32'sd13107;
	localparam logic signed [31:0] K_140     = 32'sd9175040;
	localparam logic signed [31:0] K_RESET_V = -32'sd4259840;
	localparam logic signed [31:0] K_U_JUMP  = 32'sd393216;
	localparam logic signed [31:0] K_TH_BASE = 32'sd1310720;

	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] SEED_RESET = 16'd44257;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh007FFFFFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 40'shFF80000000;

	// Register map, as word indexes.
	typedef enum logic [2:0] {
		REG_SPIKE_SIZE    = 3'd0,
		REG_STEP_SCALE    = 3'd1,
		REG_INIT_VOLTAGE  = 3'd2,
		REG_INIT_RECOVERY = 3'd3,
		REG_INIT_SPIKE    = 3'd4,
		REG_LFSR_SEED     = 3'd5
	} reg_idx_t;

	// Sequencer states. Each multiply state issues one product to the shared multiplier.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_DTQ,
		ST_VV,
		ST_P04,
		ST_P02V,
		ST_DTDV,
		ST_DTDU,
		ST_WB,
		ST_INIT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [31:0] r;
		if (x > SUM_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (x < SUM_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext(input logic signed [31:0] x);
		return SUM_W'(x);
	endfunction

	function automatic logic [15:0] lfsr_next(input logic [15:0] s);
		return (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
	endfunction

endpackage

FILE: hw/rtl/izhnp_qmul.sv
// Shared Q16.16 multiplier: the full product is registered, then shifted
// down with rounding toward minus infinity and saturated to 32 bits.
module izhnp_qmul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] q
);

	logic signed [63:0] prod_q;
	logic signed [63:0] shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	// Arithmetic shift of a two's complement value is a floor division.
	assign shifted = prod_q >>> 16;

	always_comb begin
		if (shifted > 64'sh000000007FFFFFFF) begin
			q = 32'sh7FFFFFFF;
		end else if (shifted < -64'sh0000000080000000) begin
			q = 32'sh80000000;
		end else begin
			q = shifted[31:0];
		end
	end

endmodule

FILE: hw/rtl/izhnp_neuron_pool_unit.sv
// Izhikevich neuron pool. Each input transfer is one time tick: tdata carries
// the drive current shared by all neurons, tuser the run flag. With run set,
// every neuron in turn does one Euler step of its voltage and recovery and is
// compared with a random firing threshold; with run clear the pool reloads its
// initial values and the threshold generator reloads its seed. One output
// transfer follows per neuron, index 0 first, and the last of the tick carries
// tlast and the spike count. All neuron arithmetic runs through a single
// 32x32 multiplier under a small sequencer: a running tick first forms the
// scaled step, then gives each neuron five products and a write-back, and a
// reinitialising tick reloads one neuron after another. The input is not
// ready while a tick is in progress, and a stalled output holds the sequencer
// at the next write-back or reload. The output register lets a new tick be
// accepted while the final result of the previous one still waits.
// Registers sit on an APB port at byte addresses 0, 4, ... 20 in the order
// spike size, step scale, initial voltage, initial recovery, initial spike
// value and seed; writes are to be made only while the pool is idle.
module izhikevich_neuron_pool_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] drive_current
	input  logic        s_tuser,   // [0] run

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [4:0] neuron_index, [36:5] voltage,
	                               // [68:37] spike_value, [74:69] spike_count, rest zero
	output logic        m_tlast,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int N = izhnp_pkg::NEURONS;
	localparam int W = izhnp_pkg::IDX_W;
	localparam int SW = izhnp_pkg::SUM_W;

	// Configuration registers.
	logic signed [31:0] spike_size_q;
	logic [30:0]        step_scale_q;
	logic signed [31:0] init_voltage_q;
	logic signed [31:0] init_recovery_q;
	logic signed [31:0] init_spike_q;
	logic [15:0]        lfsr_seed_q;

	// Neuron state, one entry per neuron, cleared by reset.
	logic signed [31:0] v_mem_q [N];
	logic signed [31:0] u_mem_q [N];
	logic signed [31:0] s_mem_q [N];
	logic [15:0]        lfsr_q;

	// Sequencer and working registers.
	izhnp_pkg::state_t state_q, state_nxt;
	logic [W-1:0]                   idx_q;
	logic [izhnp_pkg::CNT_W-1:0]    cnt_q;
	logic signed [31:0]             drive_q;
	logic signed [31:0]             dt02_q;
	logic signed [SW-1:0]           base_q;
	logic signed [31:0]             dv_q;
	logic signed [31:0]             du_q;
	logic signed [31:0]             vv_q;

	// Output register.
	logic                           m_tvalid_q;
	logic                           m_tlast_q;
	logic [izhnp_pkg::NIDX_W-1:0]   out_idx_q;
	logic signed [31:0]             out_v_q;
	logic signed [31:0]             out_s_q;
	logic [izhnp_pkg::CNT_W-1:0]    out_cnt_q;

	// Multiplier hookup.
	logic               mul_en;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] mul_q;

	logic               in_xfer;
	logic               cfg_wr;
	logic               out_free;
	logic               step_done;
	logic               is_last;
	logic signed [31:0] v_cur;
	logic signed [31:0] u_cur;
	logic signed [31:0] dt_op;
	logic signed [31:0] uu;
	logic signed [31:0] uu_jump;
	logic signed [31:0] th;
	logic [15:0]        lfsr_adv;
	logic [15:0]        seed_eff;
	logic               fire;
	logic               counted;
	logic signed [31:0] five_v;

	izhnp_qmul u_qmul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_q)
	);

	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign is_last   = (idx_q == W'(N - 1));
	assign v_cur     = v_mem_q[idx_q];
	assign u_cur     = u_mem_q[idx_q];
	assign dt_op     = $signed({1'b0, step_scale_q});
	assign seed_eff  = (lfsr_seed_q == 16'd0) ? 16'd1 : lfsr_seed_q;

	// Write-back arithmetic: the last product is the recovery increment.
	assign uu       = izhnp_pkg::sat32(izhnp_pkg::ext(u_cur) + izhnp_pkg::ext(mul_q));
	assign uu_jump  = izhnp_pkg::sat32(izhnp_pkg::ext(uu) +
		izhnp_pkg::ext(izhnp_pkg::K_U_JUMP));
	assign lfsr_adv = izhnp_pkg::lfsr_next(lfsr_q);
	// Threshold is 20.0 plus 20 raw steps per unit of the generator value.
	assign th       = izhnp_pkg::K_TH_BASE + $signed({12'd0, lfsr_adv, 4'd0}) +
		$signed({14'd0, lfsr_adv, 2'd0});
	assign fire     = (vv_q >= th);
	assign counted  = fire && (spike_size_q > 32'sd0);
	assign five_v   = izhnp_pkg::sat32((izhnp_pkg::ext(v_cur) <<< 2) + izhnp_pkg::ext(v_cur));

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			izhnp_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = s_tuser ? izhnp_pkg::ST_DT : izhnp_pkg::ST_INIT;
				end
			end
			izhnp_pkg::ST_DT:   state_nxt = izhnp_pkg::ST_DTQ;
			izhnp_pkg::ST_DTQ:  state_nxt = izhnp_pkg::ST_VV;
			izhnp_pkg::ST_VV:   state_nxt = izhnp_pkg::ST_P04;
			izhnp_pkg::ST_P04:  state_nxt = izhnp_pkg::ST_P02V;
			izhnp_pkg::ST_P02V: state_nxt = izhnp_pkg::ST_DTDV;
			izhnp_pkg::ST_DTDV: state_nxt = izhnp_pkg::ST_DTDU;
			izhnp_pkg::ST_DTDU: state_nxt = izhnp_pkg::ST_WB;
			izhnp_pkg::ST_WB: begin
				if (out_free) begin
					state_nxt = is_last ? izhnp_pkg::ST_IDLE : izhnp_pkg::ST_VV;
				end
			end
			izhnp_pkg::ST_INIT: begin
				if (out_free && is_last) begin
					state_nxt = izhnp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = izhnp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operands and handshake.
	always_comb begin
		mul_en    = 1'b0;
		mul_a     = dt_op;
		mul_b     = izhnp_pkg::K_0P02;
		s_tready  = 1'b0;
		step_done = 1'b0;
		case (state_q)
			izhnp_pkg::ST_IDLE: s_tready = 1'b1;
			izhnp_pkg::ST_DT: begin
				mul_en = 1'b1;
			end
			izhnp_pkg::ST_VV: begin
				mul_en = 1'b1;
				mul_a  = v_cur;
				mul_b  = v_cur;
			end
			izhnp_pkg::ST_P04: begin
				mul_en = 1'b1;
				mul_a  = izhnp_pkg::K_0P04;
				mul_b  = mul_q;
			end
			izhnp_pkg::ST_P02V: begin
				mul_en = 1'b1;
				mul_a  = izhnp_pkg::K_0P2;
				mul_b  = v_cur;
			end
			izhnp_pkg::ST_DTDV: begin
				mul_en = 1'b1;
				mul_a  = dt_op;
				mul_b  = dv_q;
			end
			izhnp_pkg::ST_DTDU: begin
				mul_en = 1'b1;
				mul_a  = dt02_q;
				mul_b  = du_q;
			end
			izhnp_pkg::ST_WB:   step_done = out_free;
			izhnp_pkg::ST_INIT: step_done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= izhnp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Intermediate results. Each one that needs a product takes it as it leaves
	// the multiplier, in the state after the multiply was issued.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			drive_q <= $signed(s_tdata);
		end
		case (state_q)
			izhnp_pkg::ST_DTQ:  dt02_q <= mul_q;
			izhnp_pkg::ST_VV:   base_q <= izhnp_pkg::ext(five_v) +
				izhnp_pkg::ext(izhnp_pkg::K_140) - izhnp_pkg::ext(u_cur) +
				izhnp_pkg::ext(drive_q);
			izhnp_pkg::ST_P02V: dv_q <= izhnp_pkg::sat32(izhnp_pkg::ext(mul_q) + base_q);
			izhnp_pkg::ST_DTDV: du_q <= izhnp_pkg::sat32(izhnp_pkg::ext(mul_q) -
				izhnp_pkg::ext(u_cur));
			izhnp_pkg::ST_DTDU: vv_q <= izhnp_pkg::sat32(izhnp_pkg::ext(v_cur) +
				izhnp_pkg::ext(mul_q));
			default: ;
		endcase
	end

	// Neuron counter, spike count, threshold generator and neuron state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			lfsr_q <= izhnp_pkg::SEED_RESET;
			for (int i = 0; i < N; i++) begin
				v_mem_q[i] <= '0;
				u_mem_q[i] <= '0;
				s_mem_q[i] <= '0;
			end
		end else begin
			if (in_xfer) begin
				idx_q <= '0;
				cnt_q <= '0;
				if (!s_tuser) begin
					lfsr_q <= seed_eff;
				end
			end else if (step_done) begin
				if (!is_last) begin
					idx_q <= idx_q + W'(1);
				end
				if (state_q == izhnp_pkg::ST_WB) begin
					lfsr_q <= lfsr_adv;
					cnt_q  <= cnt_q + izhnp_pkg::CNT_W'(counted);
					if (fire) begin
						v_mem_q[idx_q] <= izhnp_pkg::K_RESET_V;
						u_mem_q[idx_q] <= uu_jump;
						s_mem_q[idx_q] <= spike_size_q;
					end else begin
						v_mem_q[idx_q] <= vv_q;
						u_mem_q[idx_q] <= uu;
						s_mem_q[idx_q] <= '0;
					end
				end else begin
					v_mem_q[idx_q] <= init_voltage_q;
					u_mem_q[idx_q] <= init_recovery_q;
					s_mem_q[idx_q] <= init_spike_q;
				end
			end
		end
	end

	// Output register: loaded with each neuron's result as it is written back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_done) begin
			out_idx_q <= izhnp_pkg::NIDX_W'(idx_q);
			m_tlast_q <= is_last;
			if (state_q == izhnp_pkg::ST_WB) begin
				out_v_q   <= fire ? izhnp_pkg::K_RESET_V : vv_q;
				out_s_q   <= fire ? spike_size_q : 32'sd0;
				out_cnt_q <= is_last ? (cnt_q + izhnp_pkg::CNT_W'(counted)) : '0;
			end else begin
				out_v_q   <= init_voltage_q;
				out_s_q   <= init_spike_q;
				out_cnt_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {5'd0, out_cnt_q, out_s_q, out_v_q, out_idx_q};

	// Configuration registers. Addresses beyond the map are ignored on write
	// and read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spike_size_q    <= 32'sd65536;
			step_scale_q    <= 31'd65536;
			init_voltage_q  <= izhnp_pkg::K_RESET_V;
			init_recovery_q <= '0;
			init_spike_q    <= '0;
			lfsr_seed_q     <= izhnp_pkg::SEED_RESET;
		end else if (cfg_wr) begin
			case (izhnp_pkg::reg_idx_t'(paddr[4:2]))
				izhnp_pkg::REG_SPIKE_SIZE:    spike_size_q    <= $signed(pwdata);
				izhnp_pkg::REG_STEP_SCALE:    step_scale_q    <= pwdata[30:0];
				izhnp_pkg::REG_INIT_VOLTAGE:  init_voltage_q  <= $signed(pwdata);
				izhnp_pkg::REG_INIT_RECOVERY: init_recovery_q <= $signed(pwdata);
				izhnp_pkg::REG_INIT_SPIKE:    init_spike_q    <= $signed(pwdata);
				izhnp_pkg::REG_LFSR_SEED:     lfsr_seed_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (izhnp_pkg::reg_idx_t'(paddr[4:2]))
			izhnp_pkg::REG_SPIKE_SIZE:    prdata = spike_size_q;
			izhnp_pkg::REG_STEP_SCALE:    prdata = {1'b0, step_scale_q};
			izhnp_pkg::REG_INIT_VOLTAGE:  prdata = init_voltage_q;
			izhnp_pkg::REG_INIT_RECOVERY: prdata = init_recovery_q;
			izhnp_pkg::REG_INIT_SPIKE:    prdata = init_spike_q;
			izhnp_pkg::REG_LFSR_SEED:     prdata = {16'd0, lfsr_seed_q};
			default:                      prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

endmodule
